[src/stsi_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted table package
// Shared codes, widths and the control bundle that the top level hands
// to every table cell.
// ---------------------------------------------------------------------------
package stsi_pkg;

    // Default number of table entries.
    localparam int DEPTH_DEF = 32;

    // Field widths of a request and a result.
    localparam int OP_W     = 2;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 6;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Per-cycle commands broadcast to the row of cells.
    typedef struct packed {
        logic cap;     // capture the compare flag against the new request
        logic wr_ins;  // apply an insert
        logic wr_rem;  // apply a remove
        logic wr_mod;  // apply a modify
    } t_cell_ctl;

endpackage

[src/sorted_table_insert_remove.sv]
// ---------------------------------------------------------------------------
// Sorted table with insert, remove and modify
// Keeps an ascending list of signed 32-bit values in a row of cells, one
// entry per cell. Inserts go after equal values, removes close the gap.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata: value, position; tuser: operation
//  m_axis   | out       | tdata: removed_value, status, entry_count
//
// Each request: every cell captures its compare flag as it is taken, then
// the slot flag ripples through the row and all cells are written.
// A new request is taken once the previous one is written, even while its
// result still waits in the output register. If that register is still
// full when the write is due, the write waits until the result is taken.
// Reset empties the table; entry contents are not cleared.
// ---------------------------------------------------------------------------
module sorted_table_insert_remove #(
    parameter int DEPTH = stsi_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] value, [37:32] position, [39:38] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] removed_value, [33:32] status, [39:34] entry_count
    output logic [39:0] m_axis_tdata
);
    import stsi_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    logic [OP_W-1:0]         r_op;
    logic signed [VAL_W-1:0] r_val;
    logic [POS_W-1:0]        r_pos;
    logic [CW-1:0]           r_count;
    logic                    r_m_valid;
    logic [VAL_W-1:0]        r_removed;
    logic [STATUS_W-1:0]     r_status;
    logic [CNT_W-1:0]        r_cnt_out;

    logic [CW-1:0]           n_count;
    logic [STATUS_W-1:0]     n_status;
    logic [VAL_W-1:0]        n_removed;

    logic                    accept;
    logic                    go;
    logic                    full;
    logic                    pos_ok;
    logic [PW-1:0]           pos_ext;
    logic signed [VAL_W-1:0] in_val;
    t_cell_ctl               ctl;

    logic                    found [DEPTH+1];
    logic [VAL_W-1:0]        acc   [DEPTH+1];
    logic signed [VAL_W-1:0] entry [DEPTH];

    // Handshake and decode. No request is taken while reset is held.
    always_comb begin
        s_axis_tready = i_rst_n && (r_state == S_IDLE);
        accept        = s_axis_tvalid && s_axis_tready;
        go            = (r_state == S_EXEC) && (!r_m_valid || m_axis_tready);
        in_val        = $signed(s_axis_tdata[VAL_W-1:0]);
        pos_ext       = PW'(r_pos);
        full          = (r_count == CW'(DEPTH));
        pos_ok        = (pos_ext != '0) && (pos_ext <= PW'(r_count));

        ctl.cap    = accept;
        ctl.wr_ins = go && (r_op == OP_INSERT) && !full;
        ctl.wr_rem = go && (r_op == OP_REMOVE) && pos_ok;
        ctl.wr_mod = go && (r_op == OP_MODIFY) && pos_ok;
    end

    // Result and new fill level.
    always_comb begin
        n_count = r_count;
        if (ctl.wr_ins) begin
            n_count = r_count + CW'(1);
        end else if (ctl.wr_rem) begin
            n_count = r_count - CW'(1);
        end

        n_status = ST_OK;
        if (r_op == OP_INSERT && full) begin
            n_status = ST_FULL;
        end else if ((r_op == OP_REMOVE || r_op == OP_MODIFY) && !pos_ok) begin
            n_status = ST_BAD_POS;
        end

        n_removed = ctl.wr_rem ? acc[DEPTH] : '0;
    end

    // Row of cells.
    assign found[0] = 1'b0;
    assign acc[0]   = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VAL_W-1:0] left_entry;
        logic signed [VAL_W-1:0] right_entry;

        if (g == 0) begin : g_first
            assign left_entry = '0;
        end else begin : g_mid
            assign left_entry = entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = entry[g+1];
        end

        stsi_cell #(
            .IDX (g),
            .CW  (CW),
            .PW  (PW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_count       (r_count),
            .i_pos         (pos_ext),
            .i_cmp_val     (in_val),
            .i_new_val     (r_val),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .i_found       (found[g]),
            .o_found       (found[g+1]),
            .i_acc         (acc[g]),
            .o_acc         (acc[g+1]),
            .o_entry       (entry[g])
        );
    end

    // Sequencer, fill level and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_op    <= s_axis_tuser;
                r_val   <= in_val;
                r_pos   <= s_axis_tdata[VAL_W+POS_W-1:VAL_W];
                r_state <= S_EXEC;
            end
            if (go) begin
                r_state   <= S_IDLE;
                r_count   <= n_count;
                r_m_valid <= 1'b1;
                r_removed <= n_removed;
                r_status  <= n_status;
                r_cnt_out <= CNT_W'(n_count);
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_cnt_out, r_status, r_removed};

    // The table never holds more than DEPTH entries.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above table depth");

    // The fill level only moves in the cycle a request is written.
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !go) |=> (r_count == $past(r_count)))
        else $error("entry count changed while a request was pending");

    // A full status is only reported with a full table.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && n_status == ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status with room left");

    // An accepted request is written before another is taken.
    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("second request taken while one is pending");

endmodule

[src/stsi_cell.sv]
// ---------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry. Compares it with an incoming value, passes the
// "greater entry seen" flag and the removed value on to the next cell, and
// takes its new contents from itself, a neighbor or the request value.
// ---------------------------------------------------------------------------
module stsi_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6,
    parameter int PW  = 6
) (
    input  logic                              i_clk,
    input  stsi_pkg::t_cell_ctl               i_ctl,
    input  logic [CW-1:0]                     i_count,
    input  logic [PW-1:0]                     i_pos,
    input  logic signed [stsi_pkg::VAL_W-1:0] i_cmp_val,
    input  logic signed [stsi_pkg::VAL_W-1:0] i_new_val,
    input  logic signed [stsi_pkg::VAL_W-1:0] i_left_entry,
    input  logic signed [stsi_pkg::VAL_W-1:0] i_right_entry,
    input  logic                              i_found,
    output logic                              o_found,
    input  logic [stsi_pkg::VAL_W-1:0]        i_acc,
    output logic [stsi_pkg::VAL_W-1:0]        o_acc,
    output logic signed [stsi_pkg::VAL_W-1:0] o_entry
);
    import stsi_pkg::*;

    logic signed [VAL_W-1:0] r_entry;
    logic                    r_gt;
    logic signed [VAL_W-1:0] n_entry;
    logic                    held;
    logic                    at_count;
    logic                    at_pos;
    logic                    from_pos;

    // Position of this cell relative to the fill level and the request.
    always_comb begin
        held     = CW'(IDX) < i_count;
        at_count = CW'(IDX) == i_count;
        at_pos   = PW'(IDX + 1) == i_pos;
        from_pos = PW'(IDX + 1) >= i_pos;
    end

    // Next contents: insert shifts up behind the slot, remove shifts down, modify overwrites the addressed entry.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.wr_ins) begin
            if (i_found) begin
                if (held || at_count) begin
                    n_entry = i_left_entry;
                end
            end else if (r_gt || at_count) begin
                n_entry = i_new_val;
            end
        end else if (i_ctl.wr_rem) begin
            if (from_pos) begin
                n_entry = i_right_entry;
            end
        end else if (i_ctl.wr_mod) begin
            if (at_pos) begin
                n_entry = i_new_val;
            end
        end
    end

    // Entry and compare flag.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_gt <= held && (r_entry > i_cmp_val);
        end
        r_entry <= n_entry;
    end

    // Chain outputs.
    assign o_found = i_found | r_gt;
    assign o_acc   = i_acc | (at_pos ? r_entry : '0);
    assign o_entry = r_entry;

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Sorted table testbench
// Drives insert, remove, modify and unused-code requests into the sorted
// table and checks every result against a shadow copy of the table kept
// here. Covers empty and full tables, bad positions, duplicates, unsorted
// contents after a modify, random traffic with stalls on both sides, and
// a long output hold-off that backs the block up to its input.
// ---------------------------------------------------------------------------
module testbench;

    import stsi_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // Operation code that the block must treat as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One expected result.
    typedef struct {
        logic signed [VAL_W-1:0] removed;
        logic [STATUS_W-1:0]     status;
        logic [CNT_W-1:0]        count;
    } t_table_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] value, [37:32] position, [39:38] zero
    logic [39:0] s_axis_tdata = '0;
    // [1:0] operation
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] removed_value, [33:32] status, [39:34] entry_count
    logic [39:0] m_axis_tdata;

    // Shadow copy of the table contents and fill level.
    logic signed [VAL_W-1:0] shadow_entries [DEPTH];
    int                      shadow_count = 0;

    // Results still owed by the block, oldest first.
    t_table_result pending_results [$];

    int  mismatches = 0;
    bit  idling_on = 1'b1;
    int  rx_hold_cycles = 0;
    int  rx_stall_left = 0;
    int  op_seen [4] = '{0, 0, 0, 0};
    int  full_drops = 0;
    int  bad_positions = 0;
    int  peak_count = 0;

    sorted_table_insert_remove u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the shadow table and return the result it owes.
    function automatic t_table_result table_apply(input logic [OP_W-1:0] op,
                                                  input logic signed [VAL_W-1:0] val,
                                                  input logic [POS_W-1:0] pos);
        t_table_result r;
        int            slot;
        int            p;
        r.removed = '0;
        r.status  = ST_OK;
        p = int'(pos);
        case (op)
            OP_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // Goes in front of the first greater entry from the low end.
                    slot = shadow_count;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_entries[i] > val) begin
                            slot = i;
                            break;
                        end
                    end
                    for (int i = shadow_count; i > slot; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[slot] = val;
                    shadow_count++;
                end
            end
            OP_REMOVE: begin
                if (p < 1 || p > shadow_count) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.removed = shadow_entries[p-1];
                    for (int i = p - 1; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            OP_MODIFY: begin
                if (p < 1 || p > shadow_count)
                    r.status = ST_BAD_POS;
                else
                    shadow_entries[p-1] = val;
            end
            default: begin
            end
        endcase
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    // Values: full range, a narrow band for duplicates, extremes, or a copy
    // of something already held.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 16) - 8;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            default: begin
                if (shadow_count == 0)
                    return $urandom;
                return shadow_entries[$urandom_range(0, shadow_count - 1)];
            end
        endcase
    endfunction

    // Mostly a position that exists, sometimes anything the field can hold.
    function automatic logic [POS_W-1:0] pick_position();
        if (shadow_count > 0 && $urandom_range(0, 9) != 0)
            return POS_W'($urandom_range(1, shadow_count));
        return POS_W'($urandom_range(0, 63));
    endfunction

    // Send one request. Called and left at a falling edge; tvalid stays high
    // afterwards so that back-to-back requests do not drop it.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int            gap;
        t_table_result want;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {2'b00, pos, val};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = table_apply(op, val, pos);
        pending_results.push_back(want);
        op_seen[op]++;
        if (want.status == ST_FULL)
            full_drops++;
        if (want.status == ST_BAD_POS)
            bad_positions++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        @(negedge i_clk);
    endtask

    // Stop offering requests until every result has come back.
    task automatic wait_results_drained();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One random request with the given share of inserts in percent.
    task automatic send_random_request(input int insert_pct);
        int              r;
        logic [OP_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < 2)
            op = OP_UNUSED;
        else if (r < insert_pct)
            op = OP_INSERT;
        else if (r < insert_pct + (100 - insert_pct) * 2 / 3)
            op = OP_REMOVE;
        else
            op = OP_MODIFY;
        send_request(op, pick_value(), pick_position());
    endtask

    // Empty table, extremes, duplicates, unsorted contents and bad positions.
    task automatic test_directed();
        send_request(OP_REMOVE, 32'sd0, 6'd0);
        send_request(OP_REMOVE, 32'sd0, 6'd1);
        send_request(OP_MODIFY, 32'sd7, 6'd1);
        send_request(OP_UNUSED, -32'sd1, 6'd63);
        send_request(OP_INSERT, 32'sd0, 6'd0);
        send_request(OP_INSERT, 32'sh8000_0000, 6'd0);
        send_request(OP_INSERT, 32'sh7fff_ffff, 6'd63);
        send_request(OP_INSERT, -32'sd1, 6'd0);
        send_request(OP_INSERT, 32'sd0, 6'd0);
        send_request(OP_INSERT, 32'sd1, 6'd42);
        // Break the ordering, then insert into the unsorted table.
        send_request(OP_MODIFY, 32'sh7fff_ffff, 6'd1);
        send_request(OP_INSERT, 32'sd5, 6'd0);
        send_request(OP_REMOVE, 32'sd0, 6'd63);
        send_request(OP_REMOVE, 32'sd0, 6'd0);
        send_request(OP_MODIFY, 32'sd9, 6'd0);
        send_request(OP_REMOVE, 32'sd0, shadow_count[POS_W-1:0]);
        send_request(OP_REMOVE, 32'sd0, POS_W'(shadow_count + 1));
        send_request(OP_MODIFY, 32'sd3, POS_W'(shadow_count + 1));
        send_request(OP_REMOVE, 32'sd0, 6'd1);
        send_request(OP_MODIFY, 32'sh8000_0001, 6'd2);
        send_request(OP_INSERT, 32'sh5555_5555, 6'd21);
        send_request(OP_UNUSED, 32'sh2aaa_aaaa, 6'd1);
        send_request(OP_REMOVE, 32'sd0, shadow_count[POS_W-1:0]);
    endtask

    // Fill to the top, hit the full status, then empty it again.
    task automatic test_full_table();
        while (shadow_count < DEPTH)
            send_request(OP_INSERT, pick_value(), pick_position());
        repeat (3) send_request(OP_INSERT, pick_value(), pick_position());
        send_request(OP_REMOVE, 32'sd0, 6'd33);
        send_request(OP_MODIFY, 32'sd11, 6'd33);
        send_request(OP_MODIFY, 32'sh8000_0000, 6'd32);
        send_request(OP_REMOVE, 32'sd0, 6'd32);
        send_request(OP_INSERT, 32'sh7fff_ffff, 6'd0);
        send_request(OP_INSERT, 32'sd0, 6'd0);
        while (shadow_count > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_request(OP_MODIFY, pick_value(), POS_W'($urandom_range(1, shadow_count)));
            send_request(OP_REMOVE, 32'sd0, POS_W'($urandom_range(1, shadow_count)));
        end
    endtask

    // Hold the output off long enough that the block stops taking requests,
    // then let the sender wait for everything to come back.
    task automatic test_backpressure();
        idling_on = 1'b0;
        rx_hold_cycles = 80;
        repeat (12) send_random_request(60);
        wait_results_drained();
        idling_on = 1'b1;
    endtask

    // Phases that swing the table between nearly empty and full.
    task automatic test_random_traffic();
        int weights [3] = '{85, 20, 55};
        for (int phase = 0; phase < 13; phase++) begin
            idling_on = ($urandom_range(0, 3) != 0);
            repeat (100) send_random_request(weights[phase % 3]);
        end
        idling_on = 1'b1;
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        idling_on = 1'b0;
        repeat (120) send_random_request(55);
    endtask

    // Receiver: random stall bursts, plus a long hold when one is requested.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            m_axis_tready = 1'b0;
            rx_hold_cycles--;
        end else if (rx_stall_left > 0) begin
            m_axis_tready = 1'b0;
            rx_stall_left--;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready = 1'b0;
            rx_stall_left = $urandom_range(1, 14) - 1;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Compare every accepted result with the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_table_result           want;
        logic signed [VAL_W-1:0] got_removed;
        logic [STATUS_W-1:0]     got_status;
        logic [CNT_W-1:0]        got_count;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_removed = m_axis_tdata[31:0];
            got_status  = m_axis_tdata[33:32];
            got_count   = m_axis_tdata[39:34];
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata=%h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got_removed !== want.removed) begin
                    $error("removed_value: expected %0d, actual %0d",
                           want.removed, got_removed);
                    mismatches++;
                end
                if (got_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got_status);
                    mismatches++;
                end
                if (got_count !== want.count) begin
                    $error("entry_count: expected %0d, actual %0d", want.count, got_count);
                    mismatches++;
                end
            end
        end
    end

    // Sequence of tests.
    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random_traffic();
        test_full_rate();
        wait_results_drained();
        repeat (20) @(posedge i_clk);
        $display("Requests: %0d inserts, %0d removes, %0d modifies, %0d unused codes.",
                 op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_MODIFY],
                 op_seen[OP_UNUSED]);
        $display("Table peaked at %0d entries; %0d full drops, %0d bad positions.",
                 peak_count, full_drops, bad_positions);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
